[rtl/core/mexp_pkg.sv]
// Shared constants and register codes for the modular exponentiation block.
package mexp_pkg;
	localparam int MOD_BITS_DEF = 31;
	localparam int EXP_BITS_DEF = 32;
	localparam int BASE_BITS = 31;
	localparam int OUT_BITS = 31;
	localparam int ADDR_BITS = 3;
	localparam int DATA_BITS = 32;
	localparam logic [BASE_BITS-1:0] MOD_RESET = 31'd23;
	localparam logic REG_MODULUS = 1'b0;
endpackage

[rtl/core/mexp_cfg.sv]
// APB register file holding the modulus.
module mexp_cfg
	import mexp_pkg::*;
#(
	parameter int MOD_BITS = MOD_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_BITS-1:0] paddr,
	input  logic [DATA_BITS-1:0] pwdata,
	output logic [DATA_BITS-1:0] prdata,
	output logic                 pready,
	output logic [MOD_BITS-1:0]  modulus
);
	logic [MOD_BITS-1:0] modulus_q;
	logic                reg_index;

	assign reg_index = paddr[ADDR_BITS-1];
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= MOD_RESET[MOD_BITS-1:0];
		end else if (psel && penable && pwrite && pready && reg_index == REG_MODULUS) begin
			modulus_q <= pwdata[MOD_BITS-1:0];
		end
	end

	assign prdata = (reg_index == REG_MODULUS) ? DATA_BITS'(modulus_q) : '0;
	assign modulus = modulus_q;
endmodule

[rtl/core/mexp_modmul.sv]
// Bit-serial interleaved modular multiplier, one multiplier bit per cycle.
module mexp_modmul
	import mexp_pkg::*;
#(
	parameter int MOD_BITS = MOD_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [MOD_BITS-1:0]  mcand,
	input  logic [BASE_BITS-1:0] mplier,
	input  logic [MOD_BITS-1:0]  modulus,
	output logic                 done,
	output logic [MOD_BITS-1:0]  product
);
	localparam int W = MOD_BITS + 2;
	localparam int CNT_BITS = $clog2(BASE_BITS + 1);

	logic [MOD_BITS-1:0]  r_q;
	logic [MOD_BITS-1:0]  a_q;
	logic [BASE_BITS-1:0] b_q;
	logic [CNT_BITS-1:0]  cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [W-1:0]         t;
	logic [W-1:0]         m1;
	logic [W-1:0]         m2;
	logic [W-1:0]         r_next;

	always_comb begin
		m1 = {2'b00, modulus};
		m2 = {1'b0, modulus, 1'b0};
		t = {1'b0, r_q, 1'b0} + (b_q[BASE_BITS-1] ? {2'b00, a_q} : '0);
		if (t >= m2) begin
			r_next = t - m2;
		end else if (t >= m1) begin
			r_next = t - m1;
		end else begin
			r_next = t;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CNT_BITS'(BASE_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_BITS'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			r_q <= '0;
			a_q <= mcand;
			b_q <= mplier;
		end else if (busy_q) begin
			r_q <= r_next[MOD_BITS-1:0];
			b_q <= b_q << 1;
		end
	end

	assign done = done_q;
	assign product = r_q;
endmodule

[rtl/core/modular_exponentiation.sv]
// Top level: square-and-multiply sequencer around a shared modular multiplier.
// The base reduction, every squaring and every multiply for a set bit each run on the bit-serial multiplier.
// An exponent of zero or a modulus of zero skips the multiplier and goes straight to the finish state.
// One item is in work at a time; a new item can be taken while the last result still waits at the output.
// Asynchronous active-low reset idles the sequencer, empties the output and sets the modulus to 23.
module modular_exponentiation
	import mexp_pkg::*;
#(
	parameter int MOD_BITS = MOD_BITS_DEF,
	parameter int EXP_BITS = EXP_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [BASE_BITS-1:0] base_value,
	input  logic [EXP_BITS-1:0]  exponent,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [OUT_BITS-1:0]  power_result,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_BITS-1:0] paddr,
	input  logic [DATA_BITS-1:0] pwdata,
	output logic [DATA_BITS-1:0] prdata,
	output logic                 pready
);
	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_RED    = 3'd1;
	localparam logic [2:0] ST_SQ_GO  = 3'd2;
	localparam logic [2:0] ST_SQ     = 3'd3;
	localparam logic [2:0] ST_MUL_GO = 3'd4;
	localparam logic [2:0] ST_MUL    = 3'd5;
	localparam logic [2:0] ST_FIN    = 3'd6;
	localparam int ECNT_BITS = $clog2(EXP_BITS + 1);

	logic [2:0]           state_q;
	logic [MOD_BITS-1:0]  acc_q;
	logic [MOD_BITS-1:0]  base_q;
	logic [EXP_BITS-1:0]  exp_q;
	logic [ECNT_BITS-1:0] ecnt_q;
	logic [OUT_BITS-1:0]  out_q;
	logic                 out_valid_q;
	logic [MOD_BITS-1:0]  modulus;
	logic                 accept;
	logic                 mm_start;
	logic [MOD_BITS-1:0]  mm_mcand;
	logic [BASE_BITS-1:0] mm_mplier;
	logic                 mm_done;
	logic [MOD_BITS-1:0]  mm_product;
	logic                 run;

	mexp_cfg #(.MOD_BITS(MOD_BITS)) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.modulus (modulus)
	);

	mexp_modmul #(.MOD_BITS(MOD_BITS)) u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mm_start),
		.mcand   (mm_mcand),
		.mplier  (mm_mplier),
		.modulus (modulus),
		.done    (mm_done),
		.product (mm_product)
	);

	assign in_ready = (state_q == ST_IDLE);
	assign accept = in_valid && in_ready;
	assign run = (exponent != '0) && (modulus != '0);

	always_comb begin
		mm_start = 1'b0;
		mm_mcand = MOD_BITS'(1);
		mm_mplier = base_value;
		case (state_q)
			ST_IDLE: begin
				mm_start = accept && run;
			end
			ST_SQ_GO: begin
				mm_start = 1'b1;
				mm_mcand = acc_q;
				mm_mplier = BASE_BITS'(acc_q);
			end
			ST_MUL_GO: begin
				mm_start = 1'b1;
				mm_mcand = base_q;
				mm_mplier = BASE_BITS'(acc_q);
			end
			default: begin
				mm_start = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
			ecnt_q <= '0;
		end else begin
			if (state_q == ST_FIN && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= run ? ST_RED : ST_FIN;
						ecnt_q <= ECNT_BITS'(EXP_BITS);
					end
				end
				ST_RED: begin
					if (mm_done) begin
						state_q <= ST_SQ_GO;
					end
				end
				ST_SQ_GO: begin
					state_q <= ST_SQ;
				end
				ST_SQ: begin
					if (mm_done) begin
						if (exp_q[EXP_BITS-1]) begin
							state_q <= ST_MUL_GO;
						end else begin
							ecnt_q <= ecnt_q - 1'b1;
							state_q <= (ecnt_q == ECNT_BITS'(1)) ? ST_FIN : ST_SQ_GO;
						end
					end
				end
				ST_MUL_GO: begin
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					if (mm_done) begin
						ecnt_q <= ecnt_q - 1'b1;
						state_q <= (ecnt_q == ECNT_BITS'(1)) ? ST_FIN : ST_SQ_GO;
					end
				end
				ST_FIN: begin
					if (!out_valid_q || out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					exp_q <= exponent;
					if (exponent == '0) begin
						acc_q <= MOD_BITS'(1);
					end else if (modulus == '0 || modulus == MOD_BITS'(1)) begin
						acc_q <= '0;
					end else begin
						acc_q <= MOD_BITS'(1);
					end
				end
			end
			ST_RED: begin
				if (mm_done) begin
					base_q <= mm_product;
				end
			end
			ST_SQ: begin
				if (mm_done) begin
					acc_q <= mm_product;
					if (!exp_q[EXP_BITS-1]) begin
						exp_q <= exp_q << 1;
					end
				end
			end
			ST_MUL: begin
				if (mm_done) begin
					acc_q <= mm_product;
					exp_q <= exp_q << 1;
				end
			end
			ST_FIN: begin
				if (!out_valid_q || out_ready) begin
					out_q <= OUT_BITS'(acc_q);
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign power_result = out_q;
endmodule

[rtl/core/mexp_checker.sv]
// Port-level checker for the modular exponentiation block, bound to the top level.
module mexp_checker
	import mexp_pkg::*;
#(
	parameter int MOD_BITS = MOD_BITS_DEF
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_ready,
	input logic                 out_valid,
	input logic                 out_ready,
	input logic [OUT_BITS-1:0]  power_result,
	input logic                 psel,
	input logic                 penable,
	input logic                 pwrite,
	input logic [ADDR_BITS-1:0] paddr,
	input logic [DATA_BITS-1:0] pwdata,
	input logic [DATA_BITS-1:0] prdata,
	input logic                 pready
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(power_result))
		else $error("Result item changed or dropped while stalled.");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("Input ready right after an item was accepted.");

	a_pready_high: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("Register port stalled.");

	a_modulus_readback: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite && paddr[ADDR_BITS-1] == REG_MODULUS)
		##1 (!pwrite && paddr[ADDR_BITS-1] == REG_MODULUS)
		|-> prdata[MOD_BITS-1:0] == $past(pwdata[MOD_BITS-1:0]))
		else $error("Modulus readback differs from the value written.");
endmodule

bind modular_exponentiation mexp_checker #(.MOD_BITS(MOD_BITS)) u_mexp_checker (.*);
